### design/inb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inb_pkg
// shared types, constants and saturating helpers for instance_norm_backward
// ----------------------------------------------------------------------------
package inb_pkg;

    localparam int MAX_CHANNELS = 1024;
    localparam int MEM_AW       = $clog2(MAX_CHANNELS);
    localparam int CH_W         = 10;
    localparam int INV_W        = 25;

    // func codes
    localparam logic [1:0] F_ACC  = 2'd0;
    localparam logic [1:0] F_EMIT = 2'd1;
    localparam logic [1:0] F_READ = 2'd2;

    typedef logic signed [63:0] t_s64;

    typedef struct packed {
        logic start;
        logic sh24;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_rsp;

    localparam t_s64 S64_MAX = {1'b0, {63{1'b1}}};
    localparam t_s64 S64_MIN = {1'b1, {63{1'b0}}};

    function automatic t_s64 sat_add(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic t_s64 sat_sub(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input t_s64 v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

### design/instance_norm_backward.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instance_norm_backward
// instance norm gradient: plane sums, coefficients, dx, per-channel gradients
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in       | i_in_valid / o_in_ready   | func dy x mean rstd gamma channel last
//  out      | o_out_valid / i_out_ready | dx grad_gamma grad_beta
//  config   | i_cfg_we                  | inv_plane_size
//
//  one item at a time, every product through the shared multiplier: a plain
//  sample takes the dy*x product, the last sample the coefficient and gradient
//  chain, dx two products, a gradient read one memory read and one write back
//  after reset the gradient memory is cleared, no item is taken meanwhile
//  a finished result waits in the output register while the next item enters
// ----------------------------------------------------------------------------
module instance_norm_backward
    import inb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [INV_W-1:0]        i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_func,
    input  logic signed [31:0]      i_dy,
    input  logic signed [31:0]      i_x,
    input  logic signed [31:0]      i_mean,
    input  logic [30:0]             i_rstd,
    input  logic signed [31:0]      i_gamma,
    input  logic [CH_W-1:0]         i_channel,
    input  logic                    i_last,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [31:0]      o_dx,
    output logic signed [63:0]      o_grad_gamma,
    output logic signed [63:0]      o_grad_beta
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_MEMRD = 3'd4;
    localparam logic [2:0] S_MEMWB = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam logic [3:0] ST_DYX = 4'd0;
    localparam logic [3:0] ST_T2  = 4'd1;
    localparam logic [3:0] ST_T3  = 4'd2;
    localparam logic [3:0] ST_V0  = 4'd3;
    localparam logic [3:0] ST_V1  = 4'd4;
    localparam logic [3:0] ST_V2  = 4'd5;
    localparam logic [3:0] ST_V3  = 4'd6;
    localparam logic [3:0] ST_C2  = 4'd7;
    localparam logic [3:0] ST_C1  = 4'd8;
    localparam logic [3:0] ST_W0  = 4'd9;
    localparam logic [3:0] ST_W1  = 4'd10;
    localparam logic [3:0] ST_W2  = 4'd11;
    localparam logic [3:0] ST_G0  = 4'd12;
    localparam logic [3:0] ST_G1  = 4'd13;
    localparam logic [3:0] ST_DX0 = 4'd14;
    localparam logic [3:0] ST_DX1 = 4'd15;

    logic [2:0]  r_state;
    logic [3:0]  r_step;
    logic [MEM_AW-1:0] r_clr_idx;
    logic [INV_W-1:0]  r_inv;

    logic [1:0]         r_func;
    logic signed [31:0] r_dy, r_x, r_mean, r_gamma;
    logic [30:0]        r_rstd;
    logic [CH_W-1:0]    r_ch;
    logic               r_last;

    t_s64 r_sdx, r_sd, r_c1, r_c2, r_c3, r_t2, r_t3, r_v, r_w;

    logic               r_ovalid;
    logic signed [31:0] r_dx;
    t_s64               r_gg, r_gb;

    // finished result, moved to the output register once it is free
    logic signed [31:0] r_pdx;
    t_s64               r_pgg, r_pgb;

    logic [127:0] r_mem [MAX_CHANNELS];
    logic [127:0] r_rd;

    t_mul_req mreq;
    t_mul_rsp mrsp;
    t_s64     op_a, op_b, prod;
    logic     sh24;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [127:0]      mem_wdata;
    logic              ch_ok, in_acc, out_free;
    t_s64              mean64, rstd64, gamma64, inv64;

    assign ch_ok    = 32'(r_ch) < MAX_CHANNELS;
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign mean64   = 64'(r_mean);
    assign gamma64  = 64'(r_gamma);
    assign rstd64   = {33'b0, r_rstd};
    assign inv64    = {{(64-INV_W){1'b0}}, r_inv};

    // operand selection for each multiply step
    always_comb begin
        sh24 = 1'b0;
        unique case (r_step)
            ST_DYX: begin op_a = 64'(r_dy);  op_b = 64'(r_x);   end
            ST_T2:  begin op_a = r_sdx;      op_b = gamma64;    end
            ST_T3:  begin op_a = r_sd;       op_b = gamma64;    end
            ST_V0:  begin op_a = r_t3;       op_b = mean64;     end
            ST_V1:  begin op_a = r_v;        op_b = rstd64;     end
            ST_V2:  begin op_a = r_v;        op_b = rstd64;     end
            ST_V3:  begin op_a = r_v;        op_b = rstd64;     end
            ST_C2:  begin op_a = r_v;        op_b = inv64;  sh24 = 1'b1; end
            ST_C1:  begin op_a = rstd64;     op_b = gamma64;    end
            ST_W0:  begin op_a = r_c2;       op_b = mean64;     end
            ST_W1:  begin op_a = r_t3;       op_b = rstd64;     end
            ST_W2:  begin op_a = r_w;        op_b = inv64;  sh24 = 1'b1; end
            ST_G0:  begin op_a = r_sd;       op_b = mean64;     end
            ST_G1:  begin op_a = r_v;        op_b = rstd64;     end
            ST_DX0: begin op_a = r_c1;       op_b = 64'(r_dy);  end
            ST_DX1: begin op_a = r_c2;       op_b = 64'(r_x);   end
        endcase
    end

    assign mreq.start = (r_state == S_ISSUE);
    assign mreq.sh24  = sh24;

    inb_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_rsp   (mrsp),
        .o_p     (prod)
    );

    // memory port: clearing sweep, gradient write back, read-and-clear
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = MEM_AW'(r_ch);
        mem_wdata = '0;
        if (r_state == S_CLR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr_idx;
        end else if (r_state == S_MEMWB) begin
            mem_we = 1'b1;
            if (r_func == F_ACC) begin
                mem_wdata = {sat_add(r_rd[127:64], r_v), sat_add(r_rd[63:0], r_sd)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rd <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_W'(1 << 24);
        end else if (i_cfg_we) begin
            r_inv <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func  <= i_func;
            r_dy    <= i_dy;
            r_x     <= i_x;
            r_mean  <= i_mean;
            r_rstd  <= i_rstd;
            r_gamma <= i_gamma;
            r_ch    <= i_channel;
            r_last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_step    <= ST_DYX;
            r_clr_idx <= '0;
            r_ovalid  <= 1'b0;
            r_sdx     <= '0;
            r_sd      <= '0;
            r_c1      <= '0;
            r_c2      <= '0;
            r_c3      <= '0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == MEM_AW'(MAX_CHANNELS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        priority case (i_func)
                            F_ACC:  begin r_step <= ST_DYX; r_state <= S_ISSUE; end
                            F_EMIT: begin r_step <= ST_DX0; r_state <= S_ISSUE; end
                            F_READ: r_state <= S_MEMRD;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (mrsp.done) begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_ISSUE;
                        unique case (r_step)
                            ST_DYX: begin
                                r_sdx <= sat_add(r_sdx, prod);
                                r_sd  <= sat_add(r_sd, 64'(r_dy));
                                if (!r_last) r_state <= S_IDLE;
                            end
                            ST_T2:  r_t2 <= prod;
                            ST_T3:  r_t3 <= prod;
                            ST_V0:  r_v  <= sat_sub(prod, r_t2);
                            ST_V1, ST_V2, ST_V3, ST_G1: r_v <= prod;
                            ST_C2:  r_c2 <= prod;
                            ST_C1:  r_c1 <= prod;
                            ST_W0:  r_c3 <= sat_sub('0, prod);
                            ST_W1:  r_w  <= prod;
                            ST_W2: begin
                                r_c3 <= sat_sub(r_c3, prod);
                                if (!ch_ok) begin
                                    r_sdx   <= '0;
                                    r_sd    <= '0;
                                    r_state <= S_IDLE;
                                end
                            end
                            ST_G0:  r_v  <= sat_sub(r_sdx, prod);
                            ST_DX0: r_w  <= prod;
                            ST_DX1: begin
                                r_pdx   <= clamp32(sat_add(sat_add(r_w, prod), r_c3));
                                r_pgg   <= '0;
                                r_pgb   <= '0;
                                r_state <= S_EMIT;
                            end
                        endcase
                        if (r_step == ST_G1) r_state <= S_MEMRD;
                    end
                end
                S_MEMRD: begin
                    if (r_func == F_READ && !ch_ok) begin
                        r_pdx   <= '0;
                        r_pgg   <= '0;
                        r_pgb   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MEMWB;
                    end
                end
                S_MEMWB: begin
                    if (r_func == F_ACC) begin
                        r_sdx   <= '0;
                        r_sd    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_pdx   <= '0;
                        r_pgg   <= r_rd[127:64];
                        r_pgb   <= r_rd[63:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_dx    <= r_pdx;
                        r_gg    <= r_pgg;
                        r_gb    <= r_pgb;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_dx         = r_dx;
    assign o_grad_gamma = r_gg;
    assign o_grad_beta  = r_gb;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mreq.start |-> !mrsp.busy)
        else $error("multiply started while busy");

    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (!r_ovalid && !mrsp.busy))
        else $error("activity during memory clear");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == F_READ) |=> (r_state == S_MEMRD))
        else $error("gradient read did not go to memory");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !out_free) |=> (r_state == S_EMIT))
        else $error("result dropped while output busy");

endmodule

### design/inb_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inb_qmul
// multi-cycle 64x64 signed fixed point multiply, floor shift by 16 or 24,
// saturated to 64 bits; one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module inb_qmul
    import inb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    input  t_s64     i_a,
    input  t_s64     i_b,
    output t_mul_rsp o_rsp,
    output t_s64     o_p
);

    logic         r_busy, r_done, r_ppv;
    logic [2:0]   r_cnt;
    logic [63:0]  r_ua, r_ub;
    logic         r_neg, r_sh24;
    logic [63:0]  r_pp;
    logic [1:0]   r_pos;
    logic [127:0] r_acc;
    t_s64         r_res;

    logic [31:0]  a_sel, b_sel;
    logic [127:0] q, qi;
    logic         rem;
    t_s64         fin;

    assign a_sel = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign b_sel = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];

    always_comb begin
        q   = r_sh24 ? (r_acc >> 24) : (r_acc >> 16);
        rem = r_sh24 ? (|r_acc[23:0]) : (|r_acc[15:0]);
        qi  = q + 128'(r_neg & rem);
        if (!r_neg) begin
            fin = (|qi[127:63]) ? S64_MAX : {1'b0, qi[62:0]};
        end else if ((|qi[127:64]) || (qi[63] && (|qi[62:0]))) begin
            fin = S64_MIN;
        end else begin
            fin = -qi[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_ppv  <= 1'b0;
                r_acc  <= '0;
                r_ua   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
                r_ub   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_sh24 <= i_req.sh24;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                r_ppv <= !r_cnt[2];
                r_pp  <= a_sel * b_sel;
                r_pos <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                if (r_ppv) r_acc <= r_acc + (128'(r_pp) << {r_pos, 5'b0});
                if (r_cnt == 3'd5) begin
                    r_res  <= fin;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_p        = r_res;

endmodule

### verif/instance_norm_backward_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instance_norm_backward_tb
// The testbench streams planes through pass one, then through pass two, and
// reads channel gradients back. Its own fixed-point model predicts every dx
// and gradient result, and a monitor compares each result field by field.
// ----------------------------------------------------------------------------
module instance_norm_backward_tb;
    import inb_pkg::*;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] dy;
        logic signed [31:0] x;
        logic signed [31:0] mean;
        logic [30:0]        rstd;
        logic signed [31:0] gamma;
        logic [CH_W-1:0]    channel;
        logic               last;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [63:0] grad_gamma;
        logic signed [63:0] grad_beta;
    } t_grad_out;

    localparam int LIMIT = 4000000;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   cfg_we = 0;
    logic [INV_W-1:0]       cfg_wdata = '0;
    logic                   in_valid = 0;
    logic                   in_ready;
    t_sample                cur = '0;
    logic                   out_valid;
    logic                   out_ready = 0;
    logic signed [31:0]     dx;
    logic signed [63:0]     grad_gamma, grad_beta;

    t_sample   pending_q[$];
    t_grad_out grad_exp_q[$];
    int        errors = 0;
    int        n_results = 0;
    int        send_idle = 0, recv_idle = 0;
    longint    cycles = 0;

    // predictor state
    logic [INV_W-1:0] inv_size;
    t_s64 acc_dy_x, acc_dy, k_dy, k_x, k_bias;
    t_s64 g_store[MAX_CHANNELS];
    t_s64 b_store[MAX_CHANNELS];

    instance_norm_backward u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_func(cur.func), .i_dy(cur.dy), .i_x(cur.x), .i_mean(cur.mean),
        .i_rstd(cur.rstd), .i_gamma(cur.gamma), .i_channel(cur.channel),
        .i_last(cur.last), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_dx(dx), .o_grad_gamma(grad_gamma), .o_grad_beta(grad_beta)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // exact product, floor shift, saturate to 64 bits
    function automatic t_s64 fx_mul(input t_s64 a, input t_s64 b, input int s);
        logic signed [127:0] p;
        p = (128'(a) * 128'(b)) >>> s;
        if (p > 128'(S64_MAX)) return S64_MAX;
        if (p < 128'(S64_MIN)) return S64_MIN;
        return p[63:0];
    endfunction

    function automatic void predict_grad(input t_sample s);
        t_s64 t2, t3, c2, inv, rs, g;
        t_grad_out r;
        r   = '0;
        inv = t_s64'(inv_size);
        rs  = t_s64'(s.rstd);
        case (s.func)
            F_ACC: begin
                acc_dy_x = sat_add(acc_dy_x, fx_mul(s.dy, s.x, 16));
                acc_dy   = sat_add(acc_dy, t_s64'(s.dy));
                if (s.last) begin
                    t2 = fx_mul(acc_dy_x, s.gamma, 16);
                    t3 = fx_mul(acc_dy, s.gamma, 16);
                    c2 = sat_sub(fx_mul(t3, s.mean, 16), t2);
                    c2 = fx_mul(c2, rs, 16);
                    c2 = fx_mul(c2, rs, 16);
                    c2 = fx_mul(c2, rs, 16);
                    c2 = fx_mul(c2, inv, 24);
                    k_dy   = fx_mul(rs, s.gamma, 16);
                    k_x    = c2;
                    k_bias = sat_sub(sat_sub(0, fx_mul(c2, s.mean, 16)),
                                     fx_mul(fx_mul(t3, rs, 16), inv, 24));
                    if (s.channel < MAX_CHANNELS) begin
                        g = fx_mul(sat_sub(acc_dy_x, fx_mul(acc_dy, s.mean, 16)), rs, 16);
                        g_store[s.channel] = sat_add(g_store[s.channel], g);
                        b_store[s.channel] = sat_add(b_store[s.channel], acc_dy);
                    end
                    acc_dy_x = 0;
                    acc_dy   = 0;
                end
            end
            F_EMIT: begin
                r.dx = clamp32(sat_add(sat_add(fx_mul(k_dy, s.dy, 16),
                                               fx_mul(k_x, s.x, 16)), k_bias));
                grad_exp_q = {grad_exp_q, r};
            end
            F_READ: begin
                if (s.channel < MAX_CHANNELS) begin
                    r.grad_gamma = g_store[s.channel];
                    r.grad_beta  = b_store[s.channel];
                    g_store[s.channel] = 0;
                    b_store[s.channel] = 0;
                end
                grad_exp_q = {grad_exp_q, r};
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_val(input int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 65536 * 4)) - 32'd131072;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] f, input int ch, input bit lst, input int m);
        t_sample s;
        s.func    = f;
        s.dy      = rand_val(m == 9 ? $urandom_range(0, 3) : m);
        s.x       = rand_val(m == 9 ? $urandom_range(0, 3) : m);
        s.mean    = rand_val(m == 9 ? $urandom_range(0, 3) : m);
        s.rstd    = 31'(rand_val(m == 9 ? $urandom_range(0, 3) : m));
        s.gamma   = rand_val(m == 9 ? $urandom_range(0, 3) : m);
        s.channel = CH_W'(ch);
        s.last    = lst;
        pending_q = {pending_q, s};
    endtask

    // one plane: pass one ending in last, then pass two, sometimes a read back
    task automatic queue_plane(input int n, input int m, input int ch);
        for (int i = 0; i < n; i++) queue_item(F_ACC, ch, i == n - 1, m);
        for (int i = 0; i < n; i++) queue_item(F_EMIT, ch, 0, m);
        if ($urandom_range(0, 2) == 0) queue_item(F_READ, ch, 0, m);
    endtask

    task automatic drain(input int extra);
        while (pending_q.size() != 0 || in_valid || grad_exp_q.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_inv(input logic [INV_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 0;
        inv_size   = v;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch on %s: got %h, expected %h", what, got, want);
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    cur      <= pending_q[0];
                    in_valid <= 1;
                    predict_grad(pending_q.pop_front());
                end else begin
                    in_valid <= 0;
                end
            end
            out_ready <= $urandom_range(0, 99) >= recv_idle;
        end
    end

    // monitor
    always @(posedge clk) begin
        t_grad_out e;
        cycles++;
        if (out_valid && out_ready) begin
            n_results++;
            if (grad_exp_q.size() == 0) begin
                report_mismatch("unexpected item", {32'b0, dx}, 0);
            end else begin
                e = grad_exp_q.pop_front();
                if (dx !== e.dx) report_mismatch("dx", 64'(dx), 64'(e.dx));
                if (grad_gamma !== e.grad_gamma)
                    report_mismatch("grad_gamma", grad_gamma, e.grad_gamma);
                if (grad_beta !== e.grad_beta)
                    report_mismatch("grad_beta", grad_beta, e.grad_beta);
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int ch;
        inv_size = 25'h1000000;
        acc_dy_x = 0; acc_dy = 0; k_dy = 0; k_x = 0; k_bias = 0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            g_store[i] = 0;
            b_store[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1;
        send_idle = 34;
        recv_idle = 50;

        // directed: emit and read before any plane, extremes, edge channels
        queue_item(F_EMIT, 0, 0, 3);
        queue_item(F_READ, 1023, 0, 3);
        queue_item(2'd3, 5, 1, 3);
        queue_plane(2, 0, 0);
        queue_plane(2, 1, 1023);
        queue_plane(1, 2, 1023);
        queue_item(F_READ, 1023, 0, 3);
        queue_plane(3, 9, 7);
        queue_item(F_READ, 7, 0, 3);
        drain(200);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_inv(25'h1000000);
                1: write_inv(25'h0);
                default: write_inv(25'h1ffffff);
            endcase
            for (int i = 0; i < 30; i++) begin
                ch = $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 15);
                queue_plane($urandom_range(1, 6), $urandom_range(0, 9) < 7 ? 2 : 9, ch);
            end
            drain(200);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 34 : (phase == 1) ? 50 : 0;
            recv_idle = (phase == 0) ? 50 : (phase == 1) ? 34 : 0;
            write_inv(25'($urandom_range(1, 25'h1000000)));
            for (int i = 0; i < 66; i++) begin
                ch = $urandom_range(0, 31);
                if ($urandom_range(0, 9) == 0) queue_item(2'($urandom), ch, 1'($urandom), 3);
                queue_plane($urandom_range(1, 4), $urandom_range(0, 9) < 7 ? 2 : 9, ch);
            end
            for (int c = 0; c < 32; c++) queue_item(F_READ, c, 0, 3);
            drain(200);
        end

        $display("ran %0d results over planes with varied sizes, channels and scales",
                 n_results);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
design/inb_pkg.sv
design/inb_qmul.sv
design/instance_norm_backward.sv
verif/instance_norm_backward_tb.sv
